[src/vcrr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vcrr_pkg
// Shared types, sizes and helpers of the round-robin virtual channel arbiter.
// ----------------------------------------------------------------------------
package vcrr_pkg;

  localparam int NUM_VCS   = 4;
  localparam int NUM_PORTS = 8;

  // fixed field widths of the request and result beats
  localparam int MASK_W = 4;
  localparam int PORT_W = 3;

  localparam int VC_W      = $clog2(NUM_VCS);
  localparam int CNT_W     = $clog2(NUM_VCS + 1);
  localparam int PIDX_W    = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam int ENT_DEPTH = NUM_PORTS * NUM_VCS;
  localparam int ENT_AW    = $clog2(ENT_DEPTH);

  typedef struct packed {
    logic [PORT_W-1:0] port;
    logic [MASK_W-1:0] vc_nonempty;
    logic [MASK_W-1:0] vc_fits;
  } req_t;

  typedef struct packed {
    logic       granted;
    logic [1:0] granted_vc;
    logic       from_skip_list;
    logic       no_candidate;
  } res_t;

  typedef struct packed {
    logic [VC_W-1:0]  rr_pointer;
    logic [VC_W-1:0]  skip_head;
    logic [CNT_W-1:0] skip_count;
  } port_state_t;

  typedef struct packed {
    logic              en;
    logic [PIDX_W-1:0] addr;
    port_state_t       data;
  } pst_wr_t;

  typedef struct packed {
    logic              en;
    logic [ENT_AW-1:0] addr;
    logic [VC_W-1:0]   data;
  } ent_wr_t;

  // next vc index with wrap
  function automatic logic [VC_W-1:0] vc_inc(input logic [VC_W-1:0] v);
    if (int'(v) == NUM_VCS - 1) begin
      return '0;
    end
    return v + VC_W'(1);
  endfunction

  // mask bit of a vc; vcs past the mask width read as clear
  function automatic logic mask_bit(input logic [MASK_W-1:0] mask,
                                    input logic [VC_W-1:0]   v);
    logic [VC_W+1:0] ve;
    ve = {2'b00, v};
    if (int'(ve) < MASK_W) begin
      return mask[ve[1:0]];
    end
    return 1'b0;
  endfunction

  // vc index as it appears in the result field
  function automatic logic [1:0] vc_field(input logic [VC_W-1:0] v);
    logic [VC_W+1:0] ve;
    ve = {2'b00, v};
    return ve[1:0];
  endfunction

  // skip entry address: port row, vc slot
  function automatic logic [ENT_AW-1:0] ent_addr(input logic [PIDX_W-1:0] p,
                                                 input logic [VC_W-1:0]   v);
    return ENT_AW'(int'(p) * NUM_VCS + int'(v));
  endfunction

endpackage : vcrr_pkg
`default_nettype wire

[src/vcrr_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vcrr_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module vcrr_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 2
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule : vcrr_ram
`default_nettype wire

[src/vcrr_port_state.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vcrr_port_state
// Per-port pointer, skip head and skip count store with valid bits.
// ----------------------------------------------------------------------------
module vcrr_port_state (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [vcrr_pkg::PIDX_W-1:0] rd_addr,
  output vcrr_pkg::port_state_t          rd_data,
  input  wire vcrr_pkg::pst_wr_t         wr
);
  import vcrr_pkg::*;

  port_state_t          mem [NUM_PORTS];
  logic [NUM_PORTS-1:0] valid;
  port_state_t          rd_q;
  logic                 rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.en) begin
      valid[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_q     <= mem[rd_addr];
    rd_valid <= valid[rd_addr];
  end

  // a port never written reads as its reset state
  assign rd_data = rd_valid ? rd_q : '0;

endmodule : vcrr_port_state
`default_nettype wire

[src/vcrr_seq.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vcrr_seq
// Sequencer: walks the skip list, then the round-robin tries, one per cycle.
// ----------------------------------------------------------------------------
module vcrr_seq (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          req_valid,
  output logic                               req_ready,
  input  wire vcrr_pkg::req_t                req,
  output logic [vcrr_pkg::PIDX_W-1:0]        pst_rd_addr,
  input  wire vcrr_pkg::port_state_t         pst_rd_data,
  output vcrr_pkg::pst_wr_t                  pst_wr,
  output logic [vcrr_pkg::ENT_AW-1:0]        ent_rd_addr,
  input  wire logic [vcrr_pkg::VC_W-1:0]     ent_rd_data,
  output vcrr_pkg::ent_wr_t                  ent_wr,
  output logic                               res_valid,
  input  wire logic                          res_ready,
  output vcrr_pkg::res_t                     res
);
  import vcrr_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_SKIP = 3'd2;
  localparam logic [2:0] S_RR   = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]         state, state_next;
  logic [PIDX_W-1:0]  port_q, port_q_next;
  logic               in_range, in_range_next;
  logic [MASK_W-1:0]  ne_q, ne_q_next;
  logic [MASK_W-1:0]  fits_q, fits_q_next;
  logic [VC_W-1:0]    rr, rr_next;
  logic [VC_W-1:0]    head, head_next;
  logic [CNT_W-1:0]   cnt, cnt_next;
  logic [CNT_W-1:0]   n_q, n_q_next;
  logic [VC_W-1:0]    rd_ptr, rd_ptr_next;
  logic [VC_W-1:0]    wr_ptr, wr_ptr_next;
  logic [VC_W-1:0]    idx, idx_next;
  logic [NUM_VCS-1:0] listed, listed_next;
  logic               got, got_next;
  logic               from_list, from_list_next;
  logic [VC_W-1:0]    gvc, gvc_next;

  logic [CNT_W:0]     tail_sum;
  logic               req_in_range;
  logic [VC_W-1:0]    v;

  assign req_in_range = 32'(req.port) < NUM_PORTS;
  assign req_ready    = (state == S_IDLE);
  assign pst_rd_addr  = (state == S_IDLE) ? PIDX_W'(req.port) : port_q;

  // first entry is read as the port state arrives, later ones one ahead
  assign ent_rd_addr = ent_addr(port_q, (state == S_LOAD) ? pst_rd_data.skip_head
                                                          : vc_inc(rd_ptr));

  // tail slot after load: head plus count, wrapped
  assign tail_sum = (CNT_W+1)'(pst_rd_data.skip_head) + (CNT_W+1)'(pst_rd_data.skip_count);

  assign v = (state == S_SKIP) ? ent_rd_data : rr;

  assign res_valid          = (state == S_FIN);
  assign res.granted        = got;
  assign res.granted_vc     = vc_field(gvc);
  assign res.from_skip_list = from_list;
  assign res.no_candidate   = !got && (cnt == '0);

  assign pst_wr.en              = (state == S_FIN) && res_ready && in_range;
  assign pst_wr.addr            = port_q;
  assign pst_wr.data.rr_pointer = rr;
  assign pst_wr.data.skip_head  = head;
  assign pst_wr.data.skip_count = cnt;

  always_comb begin
    state_next     = state;
    port_q_next    = port_q;
    in_range_next  = in_range;
    ne_q_next      = ne_q;
    fits_q_next    = fits_q;
    rr_next        = rr;
    head_next      = head;
    cnt_next       = cnt;
    n_q_next       = n_q;
    rd_ptr_next    = rd_ptr;
    wr_ptr_next    = wr_ptr;
    idx_next       = idx;
    listed_next    = listed;
    got_next       = got;
    from_list_next = from_list;
    gvc_next       = gvc;
    ent_wr.en      = 1'b0;
    ent_wr.addr    = ent_addr(port_q, wr_ptr);
    ent_wr.data    = v;

    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          port_q_next    = PIDX_W'(req.port);
          in_range_next  = req_in_range;
          ne_q_next      = req.vc_nonempty;
          fits_q_next    = req.vc_fits;
          listed_next    = '0;
          got_next       = 1'b0;
          from_list_next = 1'b0;
          gvc_next       = '0;
          cnt_next       = '0;
          state_next     = req_in_range ? S_LOAD : S_FIN;
        end
      end
      S_LOAD: begin
        rr_next     = pst_rd_data.rr_pointer;
        cnt_next    = pst_rd_data.skip_count;
        n_q_next    = pst_rd_data.skip_count;
        rd_ptr_next = pst_rd_data.skip_head;
        idx_next    = '0;
        if (tail_sum >= (CNT_W+1)'(NUM_VCS)) begin
          wr_ptr_next = VC_W'(tail_sum - (CNT_W+1)'(NUM_VCS));
        end else begin
          wr_ptr_next = VC_W'(tail_sum);
        end
        // with no grant from the list, the head ends one full lap later
        head_next  = wr_ptr_next;
        state_next = (pst_rd_data.skip_count == '0) ? S_RR : S_SKIP;
      end
      S_SKIP: begin
        if (mask_bit(fits_q, v)) begin
          got_next       = 1'b1;
          from_list_next = 1'b1;
          gvc_next       = v;
          head_next      = vc_inc(rd_ptr);
          cnt_next       = n_q - CNT_W'(1);
          state_next     = S_FIN;
        end else begin
          // still blocked: back to the tail
          ent_wr.en      = 1'b1;
          wr_ptr_next    = vc_inc(wr_ptr);
          listed_next[v] = 1'b1;
          rd_ptr_next    = vc_inc(rd_ptr);
          if (CNT_W'(idx) == n_q - CNT_W'(1)) begin
            idx_next   = '0;
            state_next = S_RR;
          end else begin
            idx_next = idx + VC_W'(1);
          end
        end
      end
      S_RR: begin
        rr_next = vc_inc(rr);
        if (mask_bit(ne_q, v) && mask_bit(fits_q, v)) begin
          got_next   = 1'b1;
          gvc_next   = v;
          state_next = S_FIN;
        end else begin
          if (mask_bit(ne_q, v) && !listed[v] && (cnt < CNT_W'(NUM_VCS))) begin
            ent_wr.en      = 1'b1;
            wr_ptr_next    = vc_inc(wr_ptr);
            cnt_next       = cnt + CNT_W'(1);
            listed_next[v] = 1'b1;
          end
          if (int'(idx) == NUM_VCS - 1) begin
            state_next = S_FIN;
          end else begin
            idx_next = idx + VC_W'(1);
          end
        end
      end
      S_FIN: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    port_q    <= port_q_next;
    in_range  <= in_range_next;
    ne_q      <= ne_q_next;
    fits_q    <= fits_q_next;
    rr        <= rr_next;
    head      <= head_next;
    cnt       <= cnt_next;
    n_q       <= n_q_next;
    rd_ptr    <= rd_ptr_next;
    wr_ptr    <= wr_ptr_next;
    idx       <= idx_next;
    listed    <= listed_next;
    got       <= got_next;
    from_list <= from_list_next;
    gvc       <= gvc_next;
  end

endmodule : vcrr_seq
`default_nettype wire

[src/vc_round_robin_skip_arbiter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vc_round_robin_skip_arbiter
// Per-input-port virtual channel arbiter with a round-robin pointer and a
// FIFO of skipped (blocked) channels per port.
// ----------------------------------------------------------------------------
// sequence: accept, port state load, walk of up to n skip entries, then up to
//   NUM_VCS round-robin tries, result beat; a port out of range goes to the result
// a new request is taken only once the previous one has left the sequencer;
//   the skip list RAM is walked one entry per cycle
// reset: synchronous; port pointers, heads and counts read as zero through
//   per-port valid bits, skip list entries stay unwritten
// ----------------------------------------------------------------------------
module vc_round_robin_skip_arbiter (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  input  wire vcrr_pkg::req_t req,
  output logic                res_valid,
  input  wire logic           res_ready,
  output vcrr_pkg::res_t      res
);
  import vcrr_pkg::*;

  // port state store: pointer, skip head, skip count
  logic [PIDX_W-1:0] pst_rd_addr;
  port_state_t       pst_rd_data;
  pst_wr_t           pst_wr;

  // skip list entries, one row of NUM_VCS slots per port
  logic [ENT_AW-1:0] ent_rd_addr;
  logic [VC_W-1:0]   ent_rd_data;
  ent_wr_t           ent_wr;

  // sequencer result, before the output register
  logic seq_res_valid;
  logic seq_res_ready;
  res_t seq_res;

  vcrr_port_state u_port_state (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (pst_rd_addr),
    .rd_data (pst_rd_data),
    .wr      (pst_wr)
  );

  vcrr_ram #(
    .DEPTH (ENT_DEPTH),
    .WIDTH (VC_W)
  ) u_skip_ram (
    .clk     (clk),
    .wr_en   (ent_wr.en),
    .wr_addr (ent_wr.addr),
    .wr_data (ent_wr.data),
    .rd_addr (ent_rd_addr),
    .rd_data (ent_rd_data)
  );

  vcrr_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .pst_rd_addr (pst_rd_addr),
    .pst_rd_data (pst_rd_data),
    .pst_wr      (pst_wr),
    .ent_rd_addr (ent_rd_addr),
    .ent_rd_data (ent_rd_data),
    .ent_wr      (ent_wr),
    .res_valid   (seq_res_valid),
    .res_ready   (seq_res_ready),
    .res         (seq_res)
  );

  // output register: a finished beat waits here while the next request runs
  assign seq_res_ready = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (seq_res_ready) begin
      res_valid <= seq_res_valid;
    end
  end

  // payload only moves when the slot is free
  always_ff @(posedge clk) begin
    if (seq_res_ready && seq_res_valid) begin
      res <= seq_res;
    end
  end

endmodule : vc_round_robin_skip_arbiter
`default_nettype wire

[src/vcrr_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vcrr_checker
// Port-level checks of the arbiter: beats in flight and beat stability.
// ----------------------------------------------------------------------------
module vcrr_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           req_valid,
  input wire logic           req_ready,
  input wire vcrr_pkg::req_t req,
  input wire logic           res_valid,
  input wire logic           res_ready,
  input wire vcrr_pkg::res_t res
);

  // requests accepted whose result beat is not yet taken
  logic [1:0] outstanding;
  logic       req_fire;
  logic       res_fire;

  assign req_fire = req_valid && req_ready;
  assign res_fire = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else if (req_fire && !res_fire) begin
      outstanding <= outstanding + 2'd1;
    end else if (res_fire && !req_fire) begin
      outstanding <= outstanding - 2'd1;
    end
  end

  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (outstanding != 2'd0))
    else $error("result beat without an accepted request");

  a_at_most_two: assert property (@(posedge clk) disable iff (rst)
    outstanding != 2'd3)
    else $error("more than two requests in flight");

  a_busy_when_full: assert property (@(posedge clk) disable iff (rst)
    (outstanding == 2'd2) |-> !req_ready)
    else $error("request taken while one runs and one result waits");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res)))
    else $error("stalled result beat changed");

  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_ready) |=> (req_valid && $stable(req)))
    else $error("stalled request beat changed");

endmodule : vcrr_checker

bind vc_round_robin_skip_arbiter vcrr_checker u_vcrr_checker (.*);
`default_nettype wire
